/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// assertion macros used by the rtl file ssg_walk
// ----------------------------------------------------------------------------
// every macro samples on clk and is disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// consequence holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/ssg_pkg.sv */
// ----------------------------------------------------------------------------
// ssg_pkg
// types and constants shared by the stencil sparsity generator files
// ----------------------------------------------------------------------------
package ssg_pkg;

  localparam int SIZE_W  = 11;
  localparam int AREA_W  = 2 * SIZE_W;
  localparam int COUNT_W = 35;
  localparam int COL_W   = 30;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int MAX_ROW = 27;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_SIZE_X  = 3'd0,
    REG_SIZE_Y  = 3'd1,
    REG_SIZE_Z  = 3'd2,
    REG_REACH_X = 3'd3,
    REG_REACH_Y = 3'd4,
    REG_REACH_Z = 3'd5
  } reg_idx_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
    logic              reach_x;
    logic              reach_y;
    logic              reach_z;
  } cfg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_PLANE,
    ST_ROW,
    ST_ADD,
    ST_WALK
  } state_t;

  // operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MUL_AREA,
    MUL_PLANE,
    MUL_ROW
  } mul_sel_t;

endpackage

/* src/ssg_node_if.sv */
// ----------------------------------------------------------------------------
// ssg_node_if
// input channel: one row node per item
// ----------------------------------------------------------------------------
interface ssg_node_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] node_x;
  logic [COORD_BITS-1:0] node_y;
  logic [COORD_BITS-1:0] node_z;

  modport source (output valid, output node_x, output node_y, output node_z, input ready);
  modport sink   (input valid, input node_x, input node_y, input node_z, output ready);
endinterface

/* src/ssg_entry_if.sv */
// ----------------------------------------------------------------------------
// ssg_entry_if
// output channel: one column entry per item
// ----------------------------------------------------------------------------
interface ssg_entry_if;
  logic                         valid;
  logic                         ready;
  logic [ssg_pkg::COUNT_W-1:0]  row_begin;
  logic [ssg_pkg::COUNT_W-1:0]  entry_pos;
  logic [ssg_pkg::COL_W-1:0]    column_node;
  logic                         row_last;

  modport source (output valid, output row_begin, output entry_pos, output column_node,
                  output row_last, input ready);
  modport sink   (input valid, input row_begin, input entry_pos, input column_node,
                  input row_last, output ready);
endinterface

/* src/ssg_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ssg_cfg_regs
// apb register file holding grid sizes and stencil reach
// ----------------------------------------------------------------------------
module ssg_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssg_pkg::ADDR_W-1:0]   paddr,
  input  logic [ssg_pkg::DATA_W-1:0]   pwdata,
  output logic [ssg_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output ssg_pkg::cfg_t                cfg
);

  localparam int SW = ssg_pkg::SIZE_W;
  localparam int DW = ssg_pkg::DATA_W;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x  <= SW'(1);
      cfg.size_y  <= SW'(1);
      cfg.size_z  <= SW'(1);
      cfg.reach_x <= 1'b1;
      cfg.reach_y <= 1'b1;
      cfg.reach_z <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        ssg_pkg::REG_SIZE_X:  cfg.size_x  <= pwdata[SW-1:0];
        ssg_pkg::REG_SIZE_Y:  cfg.size_y  <= pwdata[SW-1:0];
        ssg_pkg::REG_SIZE_Z:  cfg.size_z  <= pwdata[SW-1:0];
        ssg_pkg::REG_REACH_X: cfg.reach_x <= pwdata[0];
        ssg_pkg::REG_REACH_Y: cfg.reach_y <= pwdata[0];
        ssg_pkg::REG_REACH_Z: cfg.reach_z <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      ssg_pkg::REG_SIZE_X:  prdata = DW'(cfg.size_x);
      ssg_pkg::REG_SIZE_Y:  prdata = DW'(cfg.size_y);
      ssg_pkg::REG_SIZE_Z:  prdata = DW'(cfg.size_z);
      ssg_pkg::REG_REACH_X: prdata = DW'(cfg.reach_x);
      ssg_pkg::REG_REACH_Y: prdata = DW'(cfg.reach_y);
      ssg_pkg::REG_REACH_Z: prdata = DW'(cfg.reach_z);
      default:              prdata = '0;
    endcase
  end

endmodule

/* src/ssg_mul.sv */
// ----------------------------------------------------------------------------
// ssg_mul
// shared multiplier with registered product, used for the index offsets
// ----------------------------------------------------------------------------
module ssg_mul (
  input  logic                        clk,
  input  ssg_pkg::mul_sel_t           sel,
  input  logic [ssg_pkg::SIZE_W-1:0]  size_x,
  input  logic [ssg_pkg::SIZE_W-1:0]  size_y,
  input  logic [ssg_pkg::SIZE_W-1:0]  lo_y,
  input  logic [ssg_pkg::SIZE_W-1:0]  lo_z,
  output logic [ssg_pkg::COL_W-1:0]   q
);

  localparam int SW = ssg_pkg::SIZE_W;
  localparam int AW = ssg_pkg::AREA_W;
  localparam int PW = AW + SW;

  logic [AW-1:0] op_a;
  logic [SW-1:0] op_b;
  logic [PW-1:0] prod;

  // operand selection
  always_comb begin
    case (sel)
      ssg_pkg::MUL_AREA: begin
        op_a = AW'(size_x);
        op_b = size_y;
      end
      ssg_pkg::MUL_PLANE: begin
        op_a = q[AW-1:0];
        op_b = lo_z;
      end
      default: begin
        op_a = AW'(size_x);
        op_b = lo_y;
      end
    endcase
  end

  assign prod = PW'(op_a) * PW'(op_b);

  // product register, reduced to the index width
  always_ff @(posedge clk) begin
    q <= prod[ssg_pkg::COL_W-1:0];
  end

endmodule

/* src/ssg_walk.sv */
// ----------------------------------------------------------------------------
// ssg_walk
// clips the stencil box, sequences the multiplier and walks the neighbours
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssg_walk #(
  parameter int COORD_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ssg_pkg::cfg_t              cfg,
  input  logic [ssg_pkg::COL_W-1:0]  mul_q,
  output ssg_pkg::mul_sel_t          mul_sel,
  output logic [ssg_pkg::SIZE_W-1:0] mul_lo_y,
  output logic [ssg_pkg::SIZE_W-1:0] mul_lo_z,
  ssg_node_if.sink                   node,
  ssg_entry_if.source                entry
);

  localparam int SW = ssg_pkg::SIZE_W;
  localparam int AW = ssg_pkg::AREA_W;
  localparam int CW = ssg_pkg::COUNT_W;
  localparam int LW = ssg_pkg::COL_W;
  // width for the clip compares
  localparam int WW = ((COORD_BITS > SW) ? COORD_BITS : SW) + 1;
  // width of a coordinate inside a non-empty clipped range
  localparam int HB = ((COORD_BITS + 1) < SW) ? (COORD_BITS + 1) : SW;

  ssg_pkg::state_t state, state_next;

  logic [WW-1:0] c_w [3];
  logic [WW-1:0] r_w [3];
  logic [WW-1:0] n_w [3];
  logic [WW-1:0] lo_w [3];
  logic [WW-1:0] hi_w [3];
  logic [WW-1:0] top_w [3];
  logic [WW-1:0] nm1_w [3];
  logic          empty;

  logic [HB-1:0] lo  [3];
  logic [HB-1:0] hi  [3];
  logic [HB-1:0] cur [3];

  logic [AW-1:0] area;
  logic [LW-1:0] plane;
  logic [LW-1:0] first_row;
  logic [LW-1:0] row_base;
  logic [CW-1:0] count;
  logic [CW-1:0] begin_q;

  logic          out_valid;
  logic [CW-1:0] out_begin;
  logic [CW-1:0] out_pos;
  logic [LW-1:0] out_col;
  logic          out_last;

  logic          accept;
  logic          load;
  logic          x_end;
  logic          y_end;
  logic          z_end;
  logic          last;
  logic [LW-1:0] next_plane_row;

  // clip each axis of the incoming node
  always_comb begin
    c_w[0] = WW'(node.node_x);
    c_w[1] = WW'(node.node_y);
    c_w[2] = WW'(node.node_z);
    r_w[0] = WW'(cfg.reach_x);
    r_w[1] = WW'(cfg.reach_y);
    r_w[2] = WW'(cfg.reach_z);
    n_w[0] = WW'(cfg.size_x);
    n_w[1] = WW'(cfg.size_y);
    n_w[2] = WW'(cfg.size_z);
    empty  = 1'b0;
    for (int a = 0; a < 3; a++) begin
      lo_w[a]  = (c_w[a] >= r_w[a]) ? (c_w[a] - r_w[a]) : '0;
      top_w[a] = c_w[a] + r_w[a];
      nm1_w[a] = n_w[a] - WW'(1);
      hi_w[a]  = (top_w[a] > nm1_w[a]) ? nm1_w[a] : top_w[a];
      if ((n_w[a] == '0) || (lo_w[a] > hi_w[a])) begin
        empty = 1'b1;
      end
    end
  end

  // walk position flags
  assign x_end = (cur[0] == hi[0]);
  assign y_end = (cur[1] == hi[1]);
  assign z_end = (cur[2] == hi[2]);
  assign last  = x_end && y_end && z_end;

  assign node.ready = (state == ssg_pkg::ST_IDLE);
  assign accept     = node.valid && node.ready;
  assign load       = (state == ssg_pkg::ST_WALK) && (!out_valid || entry.ready);

  assign mul_lo_y       = SW'(lo[1]);
  assign mul_lo_z       = SW'(lo[2]);
  assign next_plane_row = first_row + LW'(area);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and multiplier select
  always_comb begin
    state_next = state;
    mul_sel    = ssg_pkg::MUL_ROW;
    case (state)
      ssg_pkg::ST_IDLE: begin
        if (accept && !empty) begin
          state_next = ssg_pkg::ST_AREA;
        end
      end
      ssg_pkg::ST_AREA: begin
        mul_sel    = ssg_pkg::MUL_AREA;
        state_next = ssg_pkg::ST_PLANE;
      end
      ssg_pkg::ST_PLANE: begin
        mul_sel    = ssg_pkg::MUL_PLANE;
        state_next = ssg_pkg::ST_ROW;
      end
      ssg_pkg::ST_ROW: begin
        mul_sel    = ssg_pkg::MUL_ROW;
        state_next = ssg_pkg::ST_ADD;
      end
      ssg_pkg::ST_ADD: begin
        state_next = ssg_pkg::ST_WALK;
      end
      ssg_pkg::ST_WALK: begin
        if (load && last) begin
          state_next = ssg_pkg::ST_IDLE;
        end
      end
      default: state_next = ssg_pkg::ST_IDLE;
    endcase
  end

  // control registers: output valid and nonzero counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        count     <= count + CW'(1);
      end else if (entry.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ssg_pkg::ST_IDLE: begin
        if (accept) begin
          for (int a = 0; a < 3; a++) begin
            lo[a]  <= lo_w[a][HB-1:0];
            hi[a]  <= hi_w[a][HB-1:0];
            cur[a] <= lo_w[a][HB-1:0];
          end
        end
      end
      ssg_pkg::ST_PLANE: area <= mul_q[AW-1:0];
      ssg_pkg::ST_ROW:   plane <= mul_q;
      ssg_pkg::ST_ADD: begin
        first_row <= plane + mul_q;
        row_base  <= plane + mul_q;
        begin_q   <= count;
      end
      ssg_pkg::ST_WALK: begin
        if (load) begin
          out_begin <= begin_q;
          out_pos   <= count;
          out_col   <= row_base + LW'(cur[0]);
          out_last  <= last;
          // step x, then y, then z
          if (!x_end) begin
            cur[0] <= cur[0] + HB'(1);
          end else begin
            cur[0] <= lo[0];
            if (!y_end) begin
              cur[1]   <= cur[1] + HB'(1);
              row_base <= row_base + LW'(cfg.size_x);
            end else begin
              cur[1] <= lo[1];
              if (!z_end) begin
                cur[2]    <= cur[2] + HB'(1);
                first_row <= next_plane_row;
                row_base  <= next_plane_row;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign entry.valid       = out_valid;
  assign entry.row_begin   = out_begin;
  assign entry.entry_pos   = out_pos;
  assign entry.column_node = out_col;
  assign entry.row_last    = out_last;

  // checks
  `ASSERT_IMPLY(a_row_bound, out_valid, CW'(out_pos - out_begin) < CW'(ssg_pkg::MAX_ROW))
  `ASSERT_NEXT(a_last_idle, load && last, state == ssg_pkg::ST_IDLE)
  `ASSERT_NEXT(a_count_step, load, count == CW'($past(count) + CW'(1)))
  `ASSERT_IMPLY(a_x_range, state == ssg_pkg::ST_WALK, (cur[0] >= lo[0]) && (cur[0] <= hi[0]))

endmodule

/* src/stencil_sparsity_generator_unit.sv */
// ----------------------------------------------------------------------------
// stencil_sparsity_generator_unit
// csr column pattern of a 3d box stencil, one neighbour entry per item
// ----------------------------------------------------------------------------
//   channel  dir  role
//   node     in   row node coordinates node_x, node_y, node_z
//   entry    out  row_begin, entry_pos, column_node, row_last per neighbour
//   apb      in   grid sizes and stencil reach, byte address 4*index
//
// after accept, a row passes the setup states AREA, PLANE, ROW and ADD,
// in which the shared multiplier forms size_x*size_y, the plane offset and
// the row offset in series, then the walk loads one entry per cycle while
// entry is not back-pressured. a node whose box clips to nothing gives no
// entries and stays in idle. node.ready is high only between rows.
// entry back-pressure stalls the walk. rst is synchronous and clears the
// configuration registers, the sequencer and the nonzero counter.
module stencil_sparsity_generator_unit #(
  parameter int COORD_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  ssg_node_if.sink                     node,
  ssg_entry_if.source                  entry,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssg_pkg::ADDR_W-1:0]   paddr,
  input  logic [ssg_pkg::DATA_W-1:0]   pwdata,
  output logic [ssg_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  ssg_pkg::cfg_t              cfg;
  ssg_pkg::mul_sel_t          mul_sel;
  logic [ssg_pkg::COL_W-1:0]  mul_q;
  logic [ssg_pkg::SIZE_W-1:0] mul_lo_y;
  logic [ssg_pkg::SIZE_W-1:0] mul_lo_z;

  // configuration registers
  ssg_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // shared multiplier
  ssg_mul u_mul (
    .clk    (clk),
    .sel    (mul_sel),
    .size_x (cfg.size_x),
    .size_y (cfg.size_y),
    .lo_y   (mul_lo_y),
    .lo_z   (mul_lo_z),
    .q      (mul_q)
  );

  // sequencer and neighbour walk
  ssg_walk #(
    .COORD_BITS (COORD_BITS)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .mul_q    (mul_q),
    .mul_sel  (mul_sel),
    .mul_lo_y (mul_lo_y),
    .mul_lo_z (mul_lo_z),
    .node     (node),
    .entry    (entry)
  );

endmodule
